// ===== rtl/assert_macros.svh =====
// Concurrent assertion helpers clocked on the block clock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a property on every edge, during reset as well.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== rtl/lfr_pkg.sv =====
`default_nettype none

package lfr_pkg;

   localparam int SEED_W   = 32;
   localparam int RAND_W   = 31;
   localparam int MULT_W   = 16;
   localparam int PROD_W   = RAND_W + MULT_W;
   localparam int WARMUP_STEPS = 20;

   localparam logic [MULT_W-1:0] MS_MULT       = 16'd48271;
   localparam logic [RAND_W-1:0] MS_MOD        = 31'h7fff_ffff;
   localparam logic [RAND_W-1:0] ZERO_SEED_SUB = 31'd89482311;

   localparam logic ACTION_DRAW = 1'b0;
   localparam logic ACTION_SEED = 1'b1;

   typedef struct packed {
      logic load_seed;
      logic use_one;
      logic mul;
      logic red;
      logic step_idx;
      logic draw_wr;
      logic ack_seed;
   } cmd_type;

   typedef struct packed {
      logic seeded;
      logic last_step;
   } sts_type;

endpackage

`default_nettype wire

// ===== rtl/lagged_fibonacci_rng.sv =====
// Draw: pointers step on the accepting edge, the two-port lag table is read through its
// registered ports, then the add and write-back load the result; a new request is taken only after that.
// Seed: TABLE_LEN+20 minimal-standard steps (627 at 607), each a multiply state then a fold
// modulo 2^31-1 state; a draw before any seed first seeds the table with value 1.
// Synchronous active-high reset clears the pointers, the seeded flag and the handshake
// state; the table holds no value until the first seed.
`default_nettype none
`include "assert_macros.svh"

module lagged_fibonacci_rng #(
   parameter int TABLE_LEN = 607,
   parameter int TAP_LAG   = 273
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] seed_value
   input  wire logic        req_tuser,   // [0] action
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [31:0] rsp_tdata,   // [30:0] random_value, [31] zero
   output      logic        rsp_tuser    // [0] seed_done
);

   lfr_pkg::cmd_type           cmd;
   lfr_pkg::sts_type           sts;
   logic [lfr_pkg::RAND_W-1:0] random_value;

   lfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_action(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .cmd       (cmd),
      .sts       (sts)
   );

   lfr_datapath #(
      .TABLE_LEN(TABLE_LEN),
      .TAP_LAG  (TAP_LAG)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .seed_value  (req_tdata),
      .random_value(random_value),
      .seed_done   (rsp_tuser)
   );

   assign rsp_tdata = {1'b0, random_value};

   `ASSERT_CLK(a_busy_after_accept, (req_tvalid && req_tready) |=> !req_tready,
      "request accepted while previous transaction still in progress")
   `ASSERT_CLK(a_seed_ack_zero, (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == 32'd0),
      "seed acknowledgment carries nonzero data")
   `ASSERT_CLK(a_no_overwrite, (cmd.draw_wr || cmd.ack_seed) && rsp_tvalid |-> rsp_tready,
      "result loaded over a pending transaction")
   `ASSERT_CLK(a_draw_seeded, cmd.step_idx |-> sts.seeded,
      "draw started on an unseeded table")

endmodule

`default_nettype wire

// ===== rtl/lfr_ram.sv =====
`default_nettype none

module lfr_ram #(
   parameter int WIDTH = 31,
   parameter int DEPTH = 607
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output      logic [WIDTH-1:0]         rd_data_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output      logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

// ===== rtl/lfr_datapath.sv =====
`default_nettype none

module lfr_datapath #(
   parameter int TABLE_LEN = 607,
   parameter int TAP_LAG   = 273
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire lfr_pkg::cmd_type           cmd,
   output      lfr_pkg::sts_type           sts,
   input  wire logic [lfr_pkg::SEED_W-1:0] seed_value,
   output      logic [lfr_pkg::RAND_W-1:0] random_value,
   output      logic                       seed_done
);

   localparam int IDX_W     = $clog2(TABLE_LEN);
   localparam int CNT_W     = $clog2(TABLE_LEN + lfr_pkg::WARMUP_STEPS);
   localparam int LAST_STEP = TABLE_LEN + lfr_pkg::WARMUP_STEPS - 1;
   localparam int FEED_INIT = (TABLE_LEN - TAP_LAG) % TABLE_LEN;
   localparam int RW        = lfr_pkg::RAND_W;

   logic [RW-1:0]              x_ff, x_in;
   logic [lfr_pkg::PROD_W-1:0] prod_ff;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [IDX_W-1:0]           tap_ff, tap_in;
   logic [IDX_W-1:0]           feed_ff, feed_in;
   logic                       seeded_ff, seeded_in;
   logic [RW-1:0]              rsp_data_ff, rsp_data_in;
   logic                       rsp_seed_ff, rsp_seed_in;

   logic [lfr_pkg::SEED_W-1:0] seed_src;
   logic [lfr_pkg::SEED_W-1:0] seed_neg;
   logic [RW-1:0]              seed_rem;
   logic [RW-1:0]              seed_red;
   logic [RW:0]                fold_sum;
   logic [RW:0]                fold_sub;
   logic [RW-1:0]              fold_val;
   logic [RW-1:0]              rd_feed;
   logic [RW-1:0]              rd_tap;
   logic [RW-1:0]              draw_sum;
   logic                       fill_en;
   logic                       wr_en;
   logic [IDX_W-1:0]           wr_addr;
   logic [RW-1:0]              wr_data;

   always_comb begin
      seed_src = cmd.use_one ? lfr_pkg::SEED_W'(1) : seed_value;
      seed_neg = seed_src + {1'b0, lfr_pkg::MS_MOD};
      if (!seed_src[lfr_pkg::SEED_W-1]) begin
         seed_rem = (seed_src[RW-1:0] == lfr_pkg::MS_MOD) ? '0 : seed_src[RW-1:0];
      end else if (seed_src[RW-1:0] == '0) begin
         seed_rem = lfr_pkg::MS_MOD - RW'(1);
      end else begin
         seed_rem = seed_neg[RW-1:0];
      end
      seed_red = (seed_rem == '0) ? lfr_pkg::ZERO_SEED_SUB : seed_rem;
   end

   always_comb begin
      fold_sum = {{(RW + 1 - lfr_pkg::MULT_W){1'b0}}, prod_ff[lfr_pkg::PROD_W-1:RW]}
               + {1'b0, prod_ff[RW-1:0]};
      fold_sub = fold_sum - {1'b0, lfr_pkg::MS_MOD};
      fold_val = (fold_sum >= {1'b0, lfr_pkg::MS_MOD}) ? fold_sub[RW-1:0] : fold_sum[RW-1:0];
   end

   assign draw_sum = rd_feed + rd_tap;
   assign fill_en  = cmd.red && (cnt_ff >= CNT_W'(lfr_pkg::WARMUP_STEPS));
   assign wr_en    = fill_en || cmd.draw_wr;
   assign wr_addr  = cmd.draw_wr ? feed_ff
                                 : IDX_W'(cnt_ff - CNT_W'(lfr_pkg::WARMUP_STEPS));
   assign wr_data  = cmd.draw_wr ? draw_sum : fold_val;

   lfr_ram #(
      .WIDTH(RW),
      .DEPTH(TABLE_LEN)
   ) u_table (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr_a(feed_ff),
      .rd_data_a(rd_feed),
      .rd_addr_b(tap_ff),
      .rd_data_b(rd_tap)
   );

   always_comb begin
      x_in        = x_ff;
      cnt_in      = cnt_ff;
      tap_in      = tap_ff;
      feed_in     = feed_ff;
      seeded_in   = seeded_ff;
      rsp_data_in = rsp_data_ff;
      rsp_seed_in = rsp_seed_ff;
      if (cmd.load_seed) begin
         x_in   = seed_red;
         cnt_in = '0;
      end
      if (cmd.red) begin
         x_in   = fold_val;
         cnt_in = cnt_ff + CNT_W'(1);
         if (sts.last_step) begin
            tap_in    = '0;
            feed_in   = IDX_W'(FEED_INIT);
            seeded_in = 1'b1;
         end
      end
      if (cmd.step_idx) begin
         tap_in  = (tap_ff == '0) ? IDX_W'(TABLE_LEN - 1) : tap_ff - IDX_W'(1);
         feed_in = (feed_ff == '0) ? IDX_W'(TABLE_LEN - 1) : feed_ff - IDX_W'(1);
      end
      if (cmd.draw_wr) begin
         rsp_data_in = draw_sum;
         rsp_seed_in = 1'b0;
      end
      if (cmd.ack_seed) begin
         rsp_data_in = '0;
         rsp_seed_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         tap_ff    <= '0;
         feed_ff   <= '0;
         seeded_ff <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         tap_ff    <= tap_in;
         feed_ff   <= feed_in;
         seeded_ff <= seeded_in;
      end
      x_ff        <= x_in;
      if (cmd.mul) begin
         prod_ff <= lfr_pkg::PROD_W'(x_ff) * lfr_pkg::PROD_W'(lfr_pkg::MS_MULT);
      end
      rsp_data_ff <= rsp_data_in;
      rsp_seed_ff <= rsp_seed_in;
   end

   assign sts.seeded    = seeded_ff;
   assign sts.last_step = (cnt_ff == CNT_W'(LAST_STEP));
   assign random_value  = rsp_data_ff;
   assign seed_done     = rsp_seed_ff;

endmodule

`default_nettype wire

// ===== rtl/lfr_ctrl.sv =====
`default_nettype none

module lfr_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output      logic             req_tready,
   input  wire logic             req_action,
   output      logic             rsp_tvalid,
   input  wire logic             rsp_tready,
   output      lfr_pkg::cmd_type cmd,
   input  wire lfr_pkg::sts_type sts
);

   typedef enum logic [2:0] {
      IDLE,
      MUL,
      RED,
      STEP,
      READ,
      SUM,
      RESP
   } state_type;

   state_type state_ff, state_in;
   logic      pend_ff, pend_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      unique case (state_ff)
         IDLE: begin
            if (req_tvalid) begin
               if (req_action == lfr_pkg::ACTION_SEED || !sts.seeded) begin
                  cmd.load_seed = 1'b1;
                  cmd.use_one   = (req_action == lfr_pkg::ACTION_DRAW);
                  pend_in       = (req_action == lfr_pkg::ACTION_DRAW);
                  state_in      = MUL;
               end else begin
                  cmd.step_idx = 1'b1;
                  state_in     = READ;
               end
            end
         end
         MUL: begin
            cmd.mul  = 1'b1;
            state_in = RED;
         end
         RED: begin
            cmd.red = 1'b1;
            if (sts.last_step) begin
               state_in = pend_ff ? STEP : RESP;
            end else begin
               state_in = MUL;
            end
         end
         STEP: begin
            cmd.step_idx = 1'b1;
            state_in     = READ;
         end
         READ: begin
            state_in = SUM;
         end
         SUM: begin
            if (out_free) begin
               cmd.draw_wr  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end
         end
         RESP: begin
            if (out_free) begin
               cmd.ack_seed = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== bench/tb_lagged_fibonacci_rng.sv =====
`default_nettype none

module tb_lagged_fibonacci_rng;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_LEN = 607;
   localparam int TAP_LAG   = 273;
   localparam int RANDOM_ITEMS = 800;
   localparam int LONG_RUN_DRAWS = 700;

   typedef struct {
      logic [31:0] data;
      logic        done;
   } rng_output_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tuser = lfr_pkg::ACTION_DRAW;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;

   logic [lfr_pkg::RAND_W-1:0] lag_words [TABLE_LEN];
   int unsigned       tap_pos = 0;
   int unsigned       feed_pos = 0;
   bit                table_seeded = 1'b0;

   rng_output_type rng_outputs_q [$];
   int          mismatch_count = 0;
   int          seed_count = 0;
   int          draw_count = 0;
   int          burst_left = 0;
   int          long_gap_pct = 10;
   int          stall_mode = 0;
   int          stall_left = 0;

   lagged_fibonacci_rng #(
      .TABLE_LEN(TABLE_LEN),
      .TAP_LAG  (TAP_LAG)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),   // [31:0] seed_value
      .req_tuser (req_tuser),   // [0] action
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),   // [30:0] random_value, [31] zero
      .rsp_tuser (rsp_tuser)    // [0] seed_done
   );

   always #10 clock = ~clock;

   function automatic logic [lfr_pkg::RAND_W-1:0] min_std_next(
         input logic [lfr_pkg::RAND_W-1:0] x);
      longint unsigned prod;
      prod = 64'(x) * 64'(lfr_pkg::MS_MULT);
      return lfr_pkg::RAND_W'(prod % 64'(lfr_pkg::MS_MOD));
   endfunction

   function automatic void reseed_table(input logic [lfr_pkg::SEED_W-1:0] raw);
      longint                     s;
      longint                     r;
      logic [lfr_pkg::RAND_W-1:0] x;
      s = longint'(signed'(raw));
      r = s % longint'(lfr_pkg::MS_MOD);
      if (r < 0) r += longint'(lfr_pkg::MS_MOD);
      if (r == 0) r = longint'(lfr_pkg::ZERO_SEED_SUB);
      x = r[lfr_pkg::RAND_W-1:0];
      repeat (lfr_pkg::WARMUP_STEPS) x = min_std_next(x);
      for (int i = 0; i < TABLE_LEN; i++) begin
         x = min_std_next(x);
         lag_words[i] = x;
      end
      tap_pos = 0;
      feed_pos = (TABLE_LEN - TAP_LAG) % TABLE_LEN;
      table_seeded = 1'b1;
   endfunction

   function automatic rng_output_type predict_rng_output(
         input logic act, input logic [lfr_pkg::SEED_W-1:0] seed);
      rng_output_type             o;
      logic [lfr_pkg::RAND_W-1:0] sum;
      if (act == lfr_pkg::ACTION_SEED) begin
         reseed_table(seed);
         o.data = '0;
         o.done = 1'b1;
      end else begin
         if (!table_seeded) reseed_table(32'd1);
         tap_pos  = (tap_pos == 0) ? TABLE_LEN - 1 : tap_pos - 1;
         feed_pos = (feed_pos == 0) ? TABLE_LEN - 1 : feed_pos - 1;
         sum = lag_words[feed_pos] + lag_words[tap_pos];
         lag_words[feed_pos] = sum;
         o.data = {1'b0, sum};
         o.done = 1'b0;
      end
      return o;
   endfunction

   task automatic send_item(input logic act, input logic [lfr_pkg::SEED_W-1:0] seed);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 99) < long_gap_pct) ? $urandom_range(15, 40)
                                                      : $urandom_range(1, 6);
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 16);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= seed;
      req_tuser  <= act;
      do @(posedge clock); while (!req_tready);
      rng_outputs_q.push_back(predict_rng_output(act, seed));
      if (act == lfr_pkg::ACTION_SEED) seed_count++;
      else draw_count++;
      burst_left--;
      if (burst_left == 0) req_tvalid <= 1'b0;
   endtask

   task automatic send_draw();
      send_item(lfr_pkg::ACTION_DRAW, $urandom());
   endtask

   task automatic end_burst();
      if (burst_left != 0) begin
         req_tvalid <= 1'b0;
         burst_left = 0;
      end
   endtask

   task automatic wait_drained();
      end_burst();
      while (rng_outputs_q.size() != 0) @(posedge clock);
   endtask

   function automatic logic [lfr_pkg::SEED_W-1:0] pick_seed();
      logic [lfr_pkg::SEED_W-1:0] k;
      k = $urandom_range(0, 16);
      case ($urandom_range(0, 5))
         0: return k;
         1: return 32'h7fff_ffff - k;
         2: return 32'h8000_0000 + k;
         3: return -k;
         default: return $urandom();
      endcase
   endfunction

   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            default: begin
               if ($urandom_range(0, 15) == 0) begin
                  stall_left = $urandom_range(1, 25);
                  rsp_tready <= 1'b0;
               end else begin
                  rsp_tready <= 1'b1;
               end
            end
         endcase
      end
   end

   always @(posedge clock) begin
      rng_output_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rng_outputs_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: unexpected result data=%h user=%b", $time, rsp_tdata, rsp_tuser);
         end else begin
            want = rng_outputs_q.pop_front();
            if (rsp_tdata !== want.data || rsp_tuser !== want.done) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: mismatch expected data=%h user=%b, got data=%h user=%b",
                           $time, want.data, want.done, rsp_tdata, rsp_tuser);
            end
         end
      end
   end

   task automatic test_unseeded_draw();
      stall_mode = 0;
      repeat (3) send_draw();
      wait_drained();
   endtask

   task automatic test_extreme_seeds();
      logic [lfr_pkg::SEED_W-1:0] seeds [7];
      seeds = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'h0000_0001,
                32'hffff_ffff, 32'h8000_0001, 32'h7fff_fffe};
      stall_mode = 1;
      foreach (seeds[i]) begin
         send_item(lfr_pkg::ACTION_SEED, seeds[i]);
         send_draw();
         send_draw();
      end
      wait_drained();
   endtask

   task automatic test_long_run();
      stall_mode = 0;
      long_gap_pct = 0;
      send_item(lfr_pkg::ACTION_SEED, $urandom());
      repeat (LONG_RUN_DRAWS / 2) send_draw();
      stall_mode = 2;
      long_gap_pct = 10;
      repeat (LONG_RUN_DRAWS - LONG_RUN_DRAWS / 2) send_draw();
      wait_drained();
   endtask

   task automatic test_random_mix();
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0) stall_mode = $urandom_range(0, 2);
         if ($urandom_range(0, 99) < 3) send_item(lfr_pkg::ACTION_SEED, pick_seed());
         else send_draw();
      end
      wait_drained();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_unseeded_draw();
      test_extreme_seeds();
      test_long_run();
      test_random_mix();
      repeat (20) @(posedge clock);
      $display("Sent %0d reseeds and %0d draws, including a draw before any seed,",
               seed_count, draw_count);
      $display("extreme seeds, full table wrap, sender gaps and receiver stalls.");
      if (mismatch_count == 0 && rng_outputs_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/lfr_pkg.sv
rtl/lfr_ram.sv
rtl/lfr_datapath.sv
rtl/lfr_ctrl.sv
rtl/lagged_fibonacci_rng.sv
bench/tb_lagged_fibonacci_rng.sv
